@@ hw/rtl/fdf_pkg.sv @@
// shared constants, types and helpers of the frame dither filter
// used by fdf_ctrl, fdf_dp and io_frame_dither_filter; no dependencies
package fdf_pkg;

  localparam int MAX_CHANNELS  = 8;
  localparam int HISTORY_DEPTH = 30;

  localparam int SLOT_W    = $clog2(HISTORY_DEPTH);
  localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int POS_W     = $clog2(3 + 2 * MAX_CHANNELS + 1);
  localparam int MEM_AW    = CH_W + SLOT_W;
  localparam int MEM_DEPTH = 2 ** MEM_AW;

  localparam int BYTE_W     = 8;
  localparam int SAMPLE_W   = 16;
  localparam int DATA_W     = 17;
  localparam int IDX_W      = 3;
  localparam int DIG_W      = 2;
  localparam int CHN_W      = 4;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_DIGITAL_BYTES   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANALOG_CHANNELS = 1'd1;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_BUTTON,
    CLS_HIGH,
    CLS_LOW
  } item_cls_e;

  typedef enum logic {
    RES_DOUBLE,
    RES_SUM
  } res_sel_e;

  typedef struct packed {
    logic      accept;
    logic      rd;
    logic      step;
    logic      take_last;
    logic      fin;
    res_sel_e  sel;
    logic      push;
  } dp_cmd_t;

  typedef struct packed {
    item_cls_e cls;
    logic      hit_cur;
    logic      hit_last;
    logic      near;
    logic      wrap;
    logic      out_free;
  } dp_sts_t;

  function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] p);
    return (p == '0) ? SLOT_W'(HISTORY_DEPTH - 1) : p - 1'b1;
  endfunction

endpackage

@@ hw/rtl/fdf_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
module fdf_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/fdf_ctrl.sv @@
// controller of the frame dither filter: item intake, history walk, result push
// depends on fdf_pkg
module fdf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fdf_pkg::dp_sts_t sts_i,
  output fdf_pkg::dp_cmd_t cmd_o
);
  import fdf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_CHK_A,
    ST_RD_B,
    ST_CHK_B,
    ST_PUSH
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (sts_i.cls)
            CLS_BUTTON: state_d = ST_PUSH;
            CLS_LOW:    state_d = ST_RD_A;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_RD_A: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_CHK_A;
      end
      ST_CHK_A: begin
        priority if (sts_i.hit_cur) begin
          if (sts_i.wrap) begin
            cmd_o.fin = 1'b1;
            state_d   = ST_PUSH;
          end else begin
            cmd_o.step = 1'b1;
            state_d    = ST_RD_A;
          end
        end else if (sts_i.near) begin
          cmd_o.take_last = 1'b1;
          if (sts_i.wrap) begin
            cmd_o.fin = 1'b1;
            state_d   = ST_PUSH;
          end else begin
            cmd_o.step = 1'b1;
            state_d    = ST_RD_B;
          end
        end else begin
          cmd_o.fin = 1'b1;
          state_d   = ST_PUSH;
        end
      end
      ST_RD_B: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_CHK_B;
      end
      ST_CHK_B: begin
        priority if (sts_i.hit_last && !sts_i.wrap) begin
          cmd_o.step = 1'b1;
          state_d    = ST_RD_B;
        end else if (!sts_i.hit_last && sts_i.hit_cur) begin
          cmd_o.fin = 1'b1;
          cmd_o.sel = RES_SUM;
          state_d   = ST_PUSH;
        end else begin
          cmd_o.fin = 1'b1;
          state_d   = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/fdf_dp.sv @@
// datapath of the frame dither filter: frame position, sample history, result registers
// depends on fdf_pkg and fdf_ram
module fdf_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fdf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fdf_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic [fdf_pkg::BYTE_W-1:0]     rx_byte_i,
  input  logic                           frame_start_i,
  input  fdf_pkg::dp_cmd_t               cmd_i,
  output fdf_pkg::dp_sts_t               sts_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           out_kind_o,
  output logic [fdf_pkg::IDX_W-1:0]      out_index_o,
  output logic [fdf_pkg::DATA_W-1:0]     out_data_o,
  output logic                           out_end_o
);
  import fdf_pkg::*;

  logic [DIG_W-1:0]    dig_q;
  logic [CHN_W-1:0]    chn_q;
  logic [POS_W-1:0]    pos_q;
  logic [BYTE_W-1:0]   hold_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [MEM_DEPTH-1:0] vld_q;
  logic                vld_rd_q;

  logic [SAMPLE_W-1:0] cur_q, last_q;
  logic [CH_W-1:0]     ch_q;
  logic [SLOT_W-1:0]   p_q;
  logic                res_kind_q, res_end_q;
  logic [IDX_W-1:0]    res_idx_q;
  logic [DATA_W-1:0]   res_data_q;

  logic                out_valid_q, out_kind_q, out_end_q;
  logic [IDX_W-1:0]    out_idx_q;
  logic [DATA_W-1:0]   out_data_q;

  logic [POS_W-1:0]    chn_ext, chans, flen, pos_eff, pos_nxt, off, ch_full;
  logic                in_frame, is_dig, is_last, out_free;
  item_cls_e           cls;
  logic                mem_we;
  logic [MEM_AW-1:0]   waddr, raddr;
  logic [SAMPLE_W-1:0] rdata, h;

  // frame position decode
  assign chn_ext  = POS_W'(chn_q);
  assign chans    = (chn_ext > POS_W'(MAX_CHANNELS)) ? POS_W'(MAX_CHANNELS) : chn_ext;
  assign flen     = POS_W'(dig_q) + (chans << 1);
  assign pos_eff  = frame_start_i ? '0 : pos_q;
  assign pos_nxt  = pos_eff + 1'b1;
  assign in_frame = (pos_eff < flen);
  assign is_dig   = (pos_eff < POS_W'(dig_q));
  assign is_last  = (pos_nxt == flen);
  assign off      = pos_eff - POS_W'(dig_q);
  assign ch_full  = off >> 1;

  always_comb begin
    priority if (!in_frame) begin
      cls = CLS_NONE;
    end else if (is_dig) begin
      cls = CLS_BUTTON;
    end else if (!off[0]) begin
      cls = CLS_HIGH;
    end else begin
      cls = CLS_LOW;
    end
  end

  assign mem_we = cmd_i.accept && (cls == CLS_LOW);
  assign waddr  = {ch_full[CH_W-1:0], slot_q};
  assign raddr  = {ch_q, p_q};

  fdf_ram #(
    .Width (SAMPLE_W),
    .Depth (MEM_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i ({hold_q, rx_byte_i}),
    .re_i    (cmd_i.rd),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // never written entries read as zero
  assign h        = vld_rd_q ? rdata : '0;
  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.cls      = cls;
  assign sts_o.hit_cur  = (h == cur_q);
  assign sts_o.hit_last = (h == last_q);
  assign sts_o.near     = (({1'b0, h} + 1'b1) == {1'b0, cur_q}) ||
                          (({1'b0, cur_q} + 1'b1) == {1'b0, h});
  assign sts_o.wrap     = (slot_prev(p_q) == slot_q);
  assign sts_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_q       <= DIG_W'(2);
      chn_q       <= CHN_W'(6);
      pos_q       <= '0;
      hold_q      <= '0;
      slot_q      <= '0;
      vld_q       <= '0;
      vld_rd_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_DIGITAL_BYTES) begin
          dig_q <= cfg_data_i[DIG_W-1:0];
        end else if (cfg_idx_i == REG_ANALOG_CHANNELS) begin
          chn_q <= cfg_data_i[CHN_W-1:0];
        end
      end
      if (cmd_i.accept) begin
        pos_q <= in_frame ? pos_nxt : pos_eff;
        if (cls == CLS_HIGH) begin
          hold_q <= rx_byte_i;
        end
      end
      if (mem_we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (cmd_i.rd) begin
        vld_rd_q <= vld_q[raddr];
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
        if (res_end_q) begin
          slot_q <= (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_end_q <= is_last;
      if (cls == CLS_BUTTON) begin
        res_kind_q <= 1'b0;
        res_idx_q  <= pos_eff[IDX_W-1:0];
        res_data_q <= {{(DATA_W - BYTE_W){1'b0}}, ~rx_byte_i};
      end else begin
        res_kind_q <= 1'b1;
        res_idx_q  <= ch_full[IDX_W-1:0];
      end
      cur_q <= {hold_q, rx_byte_i};
      ch_q  <= ch_full[CH_W-1:0];
      p_q   <= slot_prev(slot_q);
    end
    if (cmd_i.step) begin
      p_q <= slot_prev(p_q);
    end
    if (cmd_i.take_last) begin
      last_q <= h;
    end
    if (cmd_i.fin) begin
      res_data_q <= (cmd_i.sel == RES_SUM) ? ({1'b0, cur_q} + {1'b0, last_q})
                                           : {cur_q, 1'b0};
    end
    if (cmd_i.push) begin
      out_kind_q <= res_kind_q;
      out_idx_q  <= res_idx_q;
      out_data_q <= res_data_q;
      out_end_q  <= res_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_index_o = out_idx_q;
  assign out_data_o  = out_data_q;
  assign out_end_o   = out_end_q;

`ifndef ASSERT_OFF
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> out_free)
    else $error("result pushed into a busy output register");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q < SLOT_W'(HISTORY_DEPTH))
    else $error("history slot out of range");

  a_walk_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> (p_q != slot_q))
    else $error("history walk reads the current slot");

  a_write_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> vld_q[$past(waddr)])
    else $error("stored sample not marked valid");
`endif

endmodule

@@ hw/rtl/io_frame_dither_filter.sv @@
// a button byte is taken into the result registers and then pushed to the output register;
// a high sample byte gives no result; a low sample byte first reads up to 29 history entries
// throughput: one item at a time; the history walk reads its entries one after another
// through the single read port of the history ram
// reset: registers go to 2 digital bytes and 6 channels; history reads as zero through
// per-entry valid flags cleared at reset, no clearing pass
module io_frame_dither_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fdf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [fdf_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [fdf_pkg::BYTE_W-1:0]          s_axis_tdata,  // rx_byte
  input  logic                                s_axis_tuser,  // frame_start
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [fdf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // index, data, zero pad
  output logic                                m_axis_tuser,  // kind
  output logic                                m_axis_tlast   // frame_end
);
  import fdf_pkg::*;

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [IDX_W-1:0]  out_index;
  logic [DATA_W-1:0] out_data;

  fdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fdf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .rx_byte_i     (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_kind_o    (m_axis_tuser),
    .out_index_o   (out_index),
    .out_data_o    (out_data),
    .out_end_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - DATA_W - IDX_W)'(0), out_data, out_index};

endmodule

@@ sim/io_frame_dither_filter_tb.sv @@
// self-checking testbench for io_frame_dither_filter: button inversion and flicker filter
// predicts every result in a small class and compares it on the output stream
// depends on fdf_pkg and the io_frame_dither_filter rtl
module io_frame_dither_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fdf_pkg::*;

  localparam logic KIND_BUTTON   = 1'b0;
  localparam logic KIND_ANALOG   = 1'b1;
  localparam int   SETTLE_CYCLES = 80;
  localparam int   LONG_HOLD     = 300;
  localparam int   PHASE_ITEMS   = 75;

  typedef struct packed {
    logic        kind;
    logic [2:0]  index;
    logic [16:0] data;
    logic        frame_end;
  } result_t;

  class dither_frame_tracker;
    logic [15:0] history [MAX_CHANNELS][HISTORY_DEPTH];
    int unsigned slot;
    int unsigned position;
    logic [7:0]  high_hold;
    int unsigned digital_bytes;
    int unsigned analog_chans;
    result_t     pending_results[$];
    int          errors;

    function new();
      foreach (history[c, s]) history[c][s] = '0;
      slot          = 0;
      position      = 0;
      high_hold     = '0;
      digital_bytes = 2;
      analog_chans  = 6;
      errors        = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_DIGITAL_BYTES) digital_bytes = 32'(val[1:0]);
      else analog_chans = 32'(val);
    endfunction

    function int unsigned older_slot(int unsigned p);
      return (p + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
    endfunction

    function logic [16:0] filtered_sample(int unsigned ch, logic [15:0] cur);
      int unsigned p;
      int unsigned cv;
      int unsigned lv;
      logic [15:0] last;
      cv = 32'(cur);
      p  = slot;
      do p = older_slot(p); while (p != slot && history[ch][p] == cur);
      if (p == slot) return {cur, 1'b0};
      last = history[ch][p];
      lv   = 32'(last);
      if (lv + 1 == cv || cv + 1 == lv) begin
        do p = older_slot(p); while (p != slot && history[ch][p] == last);
        if (p != slot && history[ch][p] == cur) return 17'(cv + lv);
      end
      return {cur, 1'b0};
    endfunction

    function void note_byte(logic [7:0] rx, logic start);
      int unsigned chans;
      int unsigned flen;
      int unsigned pos;
      int unsigned off;
      int unsigned ch;
      logic [15:0] cur;
      result_t     r;
      chans = (analog_chans > MAX_CHANNELS) ? MAX_CHANNELS : analog_chans;
      flen  = digital_bytes + 2 * chans;
      if (start) position = 0;
      pos = position;
      if (pos >= flen) return;
      position    = pos + 1;
      r.frame_end = (pos + 1 == flen);
      if (pos < digital_bytes) begin
        r.kind  = KIND_BUTTON;
        r.index = 3'(pos);
        r.data  = {9'b0, ~rx};
      end else begin
        off = pos - digital_bytes;
        ch  = off >> 1;
        if (off % 2 == 0) begin
          high_hold = rx;
          return;
        end
        cur               = {high_hold, rx};
        history[ch][slot] = cur;
        r.kind            = KIND_ANALOG;
        r.index           = 3'(ch);
        r.data            = filtered_sample(ch, cur);
      end
      if (r.frame_end) slot = (slot + 1) % HISTORY_DEPTH;
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      $display("%0t: mismatch, %s", $time, msg);
      errors++;
    endtask

    task check_result(logic kind, logic [2:0] idx, logic [16:0] data, logic last);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected item kind %0d index %0d data %0h", kind, idx, data));
        return;
      end
      want = pending_results.pop_front();
      if (kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", kind, want.kind));
      if (idx !== want.index)
        report($sformatf("index %0d, expected %0d", idx, want.index));
      if (data !== want.data)
        report($sformatf("data %0h, expected %0h (index %0d)", data, want.data, want.index));
      if (last !== want.frame_end)
        report($sformatf("frame end %0d, expected %0d", last, want.frame_end));
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [BYTE_W-1:0]      s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  dither_frame_tracker board = new();
  logic [15:0] base_val [MAX_CHANNELS];
  int unsigned cfg_dig;
  int unsigned cfg_chan;
  int          hold_req = 0;
  bit          quiet = 1'b0;

  io_frame_dither_filter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[19:3], m_axis_tlast);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        n        = hold_req;
        hold_req = 0;
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic start);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_byte(b, start);
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    board.set_reg(idx, val);
    if (idx == REG_DIGITAL_BYTES) cfg_dig = 32'(val[1:0]);
    else cfg_chan = 32'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // samples mostly hover around a per-channel level so the flicker case shows up
  function automatic logic [15:0] pick_sample(int ch);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) base_val[ch] = $urandom_range(0, 1) ? 16'hFFFE : 16'h0000;
    else if (r < 3) base_val[ch] = 16'($urandom);
    r = $urandom_range(0, 9);
    if (r < 7) return base_val[ch] + 16'($urandom_range(0, 1));
    if (r == 7) return base_val[ch] + 16'd2;
    return 16'($urandom);
  endfunction

  task automatic run_frame(output int count);
    logic [7:0]  bytes[$];
    logic [15:0] v;
    int          nch;
    int          n;
    int          mode;
    nch = (cfg_chan > MAX_CHANNELS) ? MAX_CHANNELS : cfg_chan;
    for (int d = 0; d < cfg_dig; d++) bytes.push_back(8'($urandom));
    for (int c = 0; c < nch; c++) begin
      v = pick_sample(c);
      bytes.push_back(v[15:8]);
      bytes.push_back(v[7:0]);
    end
    mode = $urandom_range(0, 19);
    n    = bytes.size();
    if (mode == 0 && n > 1) begin
      n = $urandom_range(1, n - 1);
    end else if (mode == 1 || n == 0) begin
      repeat ($urandom_range(1, 3)) bytes.push_back(8'($urandom));
      n = bytes.size();
    end
    for (int i = 0; i < n; i++)
      send_byte(bytes[i], (i == 0) && (mode != 2));
    count = n;
  endtask

  initial begin
    int          sent;
    int          n;
    int unsigned phase_dig [9] = '{3, 0, 1, 0, 3, 2, 0, 1, 2};
    int unsigned phase_chan [9] = '{8, 1, 15, 0, 0, 3, 8, 12, 6};
    logic [15:0] edge_samples [6] = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE,
                                      16'h5A5A, 16'hA5A5};
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_dig       = 2;
    cfg_chan      = 6;
    foreach (base_val[c]) base_val[c] = 16'($urandom);
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // first frame arrives with no frame start, then bytes past its end
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    foreach (edge_samples[i]) begin
      send_byte(edge_samples[i][15:8], 1'b0);
      send_byte(edge_samples[i][7:0], 1'b0);
    end
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b0);
    // frame cut short by the next frame start
    send_byte(8'h3C, 1'b1);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h80, 1'b0);

    for (int p = 0; p < 9; p++) begin
      settle();
      cfg_write(REG_DIGITAL_BYTES, {2'($urandom), 2'(phase_dig[p])});
      cfg_write(REG_ANALOG_CHANNELS, 4'(phase_chan[p]));
      if (p == 1) hold_req = LONG_HOLD;
      if (p == 8) quiet = 1'b1;
      sent = 0;
      if (p == 5) begin
        // frame length changes while a frame is half way through
        send_byte(8'($urandom), 1'b1);
        repeat (4) send_byte(8'($urandom), 1'b0);
        settle();
        cfg_write(REG_ANALOG_CHANNELS, 4'd5);
        repeat (8) send_byte(8'($urandom), 1'b0);
        sent = 13;
      end
      while (sent < ((cfg_dig + cfg_chan == 0) ? 15 : PHASE_ITEMS)) begin
        run_frame(n);
        sent += n;
      end
    end

    settle();
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
